FILE: sv/lpc_pkg.sv
// Shared constants and types for the loop playhead with seam crossfade.
package lpc_pkg;

  localparam int POS_W    = 36;  // playhead width, 16 fractional bits
  localparam int SPOS_W   = 39;  // signed working width for moved positions
  localparam int DVD_W    = 40;  // divider dividend and quotient width
  localparam int CNT_W    = 6;   // divider step counter width
  localparam int NORM_W   = 17;
  localparam int STEP_W   = 23;
  localparam int XF_W     = 24;
  localparam int MIDX_W   = 20;
  localparam int PROD_W   = 37;

  localparam logic [NORM_W-1:0]   NORM_ONE = 17'd65536;
  localparam logic [POS_W-1:0]    ONE_POS  = 36'd65536;
  localparam logic [XF_W-1:0]     XF_MIN   = 24'd524288;   // 8 samples
  localparam logic [XF_W-1:0]     XF_MAX   = 24'd8388608;  // 128 samples
  localparam logic [NORM_W-1:0]   SEG_MIN  = 17'd66;
  localparam logic [20:0]         BUF_MAX  = 21'd1048576;
  localparam logic [15:0]         RATE_MIN = 16'd1024;
  localparam logic [15:0]         RATE_MAX = 16'd32768;

  // Loop lengths at which a tenth reaches the crossfade limits.
  localparam logic [POS_W-1:0]    XF_LEN_LO = 36'd5242880;
  localparam logic [POS_W-1:0]    XF_LEN_HI = 36'd83886080;
  // ceil(2^30 / 10); exact for lengths below 2^27.
  localparam logic [26:0]         XF_RECIP  = 27'd107374183;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_SET  = 2'd1;
  localparam logic [1:0] OP_CUT  = 2'd2;

  localparam logic [2:0] REG_BUF_LEN  = 3'd0;
  localparam logic [2:0] REG_LSTART   = 3'd1;
  localparam logic [2:0] REG_LEND     = 3'd2;
  localparam logic [2:0] REG_RATE     = 3'd3;
  localparam logic [2:0] REG_SCALE    = 3'd4;
  localparam logic [2:0] REG_REVERSE  = 3'd5;
  localparam logic [2:0] REG_PLAYING  = 3'd6;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: sv/lpc_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module lpc_div import lpc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DVD_W-1:0]   dividend_i,
  input  logic [POS_W-1:0]   divisor_i,
  output div_stat_t          stat_o,
  output logic [DVD_W-1:0]   quotient_o,
  output logic [POS_W-1:0]   remainder_o
);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVD_W-1:0] dvd_q;
  logic [POS_W-1:0] rem_q, dsr_q, rem_d;
  logic [POS_W:0]   shifted;
  logic             qbit;

  assign shifted = {rem_q, dvd_q[DVD_W-1]};
  assign qbit    = shifted >= {1'b0, dsr_q};
  assign rem_d   = qbit ? POS_W'(shifted - {1'b0, dsr_q}) : POS_W'(shifted);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[DVD_W-2:0], qbit};
    end
  end

  assign stat_o.busy  = busy_q;
  assign stat_o.done  = done_q;
  assign quotient_o   = dvd_q;
  assign remainder_o  = rem_q;

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a run");
  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> rem_q < dsr_q)
    else $error("remainder not below divisor");
`endif

endmodule

FILE: sv/loop_playhead_crossfade_top.sv
// Top level: loop playhead sequencer with shared multiplier and divider.
//
// Requests enter on the s_axis channel: tuser carries the operation (tick,
// set position, trigger cut), tdata the position value, cut index and count.
// A tick returns one result on m_axis: read position, blend position, fade
// weight, and the blend_active and silent flags in tuser. Set position and
// trigger cut return nothing. Registers are to be written over the APB port
// only while the block is idle; the block itself does not enforce this.
// One request is handled at a time; s_axis_tready is high only while the
// sequencer is idle. A tick runs the divider once for the fade weight inside
// the seam zone, and once for each wrap of a playhead that lies outside the
// loop; its result appears in the same cycle as the block becomes ready again.
// The crossfade length comes from a reciprocal multiply, registered in S_XF.
// Reset clears the playhead and loads the register defaults. When the
// receiver stalls, the result waits in the output register and the next
// request is taken; a following tick holds before its result until the
// output register is free.
module loop_playhead_crossfade_top import lpc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,  // position_value, cut_index, cut_count, zero pad
  input  logic [1:0]   s_axis_tuser,  // operation
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [95:0]  m_axis_tdata,  // main_position, blend_position, fade_weight, zero pad
  output logic [1:0]   m_axis_tuser,  // blend_active, silent
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_START  = 4'd1;
  localparam logic [3:0] S_END    = 4'd2;
  localparam logic [3:0] S_STEP   = 4'd3;
  localparam logic [3:0] S_CHK    = 4'd4;
  localparam logic [3:0] S_WRAP1  = 4'd5;
  localparam logic [3:0] S_XF     = 4'd6;
  localparam logic [3:0] S_ZONE   = 4'd7;
  localparam logic [3:0] S_FADE   = 4'd8;
  localparam logic [3:0] S_MOVE   = 4'd9;
  localparam logic [3:0] S_WRAP2  = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;
  localparam logic [3:0] S_SETMUL = 4'd12;
  localparam logic [3:0] S_CUTMUL = 4'd13;
  localparam logic [3:0] S_CUTDIV = 4'd14;

  // Configuration registers.
  logic [20:0]       buf_len_q;
  logic [NORM_W-1:0] lstart_q, lend_q;
  logic [15:0]       rate_q;
  logic [19:0]       scale_q;
  logic              reverse_q, playing_q;

  logic              wr_en;
  logic [2:0]        wr_idx;
  logic [20:0]       wv_buf;
  logic [NORM_W-1:0] wv_norm;
  logic [15:0]       wv_rate;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wr_idx = paddr[4:2];
  assign wv_buf  = (pwdata[20:0] > BUF_MAX) ? BUF_MAX : pwdata[20:0];
  assign wv_norm = (pwdata[16:0] > NORM_ONE) ? NORM_ONE : pwdata[16:0];
  assign wv_rate = (pwdata[15:0] < RATE_MIN) ? RATE_MIN :
                   (pwdata[15:0] > RATE_MAX) ? RATE_MAX : pwdata[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_len_q <= '0;
      lstart_q  <= '0;
      lend_q    <= NORM_ONE;
      rate_q    <= 16'd8192;
      scale_q   <= 20'd65536;
      reverse_q <= 1'b0;
      playing_q <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_idx)
        REG_BUF_LEN: buf_len_q <= wv_buf;
        REG_LSTART:  lstart_q  <= wv_norm;
        REG_LEND:    lend_q    <= wv_norm;
        REG_RATE:    rate_q    <= wv_rate;
        REG_SCALE:   scale_q   <= pwdata[19:0];
        REG_REVERSE: reverse_q <= pwdata[0];
        REG_PLAYING: playing_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (wr_idx)
      REG_BUF_LEN: prdata = 32'(buf_len_q);
      REG_LSTART:  prdata = 32'(lstart_q);
      REG_LEND:    prdata = 32'(lend_q);
      REG_RATE:    prdata = 32'(rate_q);
      REG_SCALE:   prdata = 32'(scale_q);
      REG_REVERSE: prdata = 32'(reverse_q);
      REG_PLAYING: prdata = 32'(playing_q);
      default:     prdata = '0;
    endcase
  end

  // Derived loop values.
  logic [NORM_W-1:0] ls;
  logic [MIDX_W-1:0] max_idx;
  assign ls      = (lstart_q < lend_q) ? lstart_q : lend_q;
  assign max_idx = (buf_len_q == '0) ? '0 : MIDX_W'(buf_len_q - 21'd1);

  // Sequencer state and working registers.
  logic [3:0]        state_q;
  logic [1:0]        op_in;
  logic [NORM_W-1:0] pos_in;
  logic [7:0]        idx_in;
  logic [8:0]        cnt_in;
  logic [7:0]        idx_q;
  logic [8:0]        cnt_q;
  logic [NORM_W-1:0] norm_q;
  logic [POS_W-1:0]  playhead_q, start_q, end_q, p_q, np_q, blend_q;
  logic [STEP_W-1:0] step_q;
  logic [XF_W-1:0]   xf_q;
  logic [NORM_W-1:0] fade_q;
  logic              active_q, silent_q, neg_q;
  logic              out_valid_q;
  logic [95:0]       out_data_q;
  logic [1:0]        out_user_q;

  assign op_in  = s_axis_tuser;
  assign pos_in = s_axis_tdata[16:0];
  assign idx_in = s_axis_tdata[24:17];
  assign cnt_in = s_axis_tdata[33:25];

  assign s_axis_tready = (state_q == S_IDLE);

  // Shared multiplier.
  logic [NORM_W-1:0] mul_a;
  logic [MIDX_W-1:0] mul_b;
  logic [PROD_W-1:0] prod;
  logic [8:0]        idx_c;
  logic [NORM_W-1:0] seg;

  assign idx_c = ({1'b0, idx_q} > (cnt_q - 9'd1)) ? (cnt_q - 9'd1) : {1'b0, idx_q};
  assign seg   = ((lend_q - ls) < SEG_MIN) ? SEG_MIN : NORM_W'(lend_q - ls);

  always_comb begin
    mul_a = norm_q;
    mul_b = max_idx;
    case (state_q)
      S_START:  mul_a = ls;
      S_END:    mul_a = lend_q;
      S_STEP: begin
        mul_a = {1'b0, rate_q};
        mul_b = scale_q;
      end
      S_CUTMUL: begin
        mul_a = seg;
        mul_b = MIDX_W'(idx_c);
      end
      default: ;
    endcase
  end
  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Signed views of positions.
  logic signed [SPOS_W-1:0] s_start, s_end, s_p, s_xf, s_moved, w_src, w_mag;
  logic [POS_W-1:0] len;
  logic             w_lt, w_in;

  assign s_start = $signed(SPOS_W'(start_q));
  assign s_end   = $signed(SPOS_W'(end_q));
  assign s_p     = $signed(SPOS_W'(p_q));
  assign s_xf    = $signed(SPOS_W'(xf_q));
  assign len     = end_q - start_q;
  assign s_moved = reverse_q ? (s_p - $signed(SPOS_W'(step_q)))
                             : (s_p + $signed(SPOS_W'(step_q)));
  assign w_src   = (state_q == S_CHK) ? $signed(SPOS_W'(playhead_q)) : s_moved;
  assign w_lt    = w_src < s_start;
  assign w_in    = !w_lt && (w_src < s_end);
  assign w_mag   = w_lt ? (s_start - w_src) : (w_src - s_start);

  // Crossfade length: a tenth of the loop, clamped. Only lengths below the
  // upper clamp reach the reciprocal multiply, so 27 bits of len suffice.
  logic [53:0]     xf_prod;
  logic [XF_W-1:0] xf_calc;
  assign xf_prod = 54'(len[26:0]) * 54'(XF_RECIP);
  assign xf_calc = (len < XF_LEN_LO)  ? XF_MIN :
                   (len >= XF_LEN_HI) ? XF_MAX : xf_prod[53:30];

  // Seam zone tests.
  logic                     zone_fwd, zone_rev, has_step;
  logic signed [SPOS_W-1:0] dist_f, dist_r, blend_r;
  assign has_step = (step_q != '0);
  assign zone_fwd = has_step && !reverse_q && (s_p + s_xf >= s_end);
  assign zone_rev = has_step && reverse_q && (s_p <= s_start + s_xf);
  assign dist_f   = s_p + s_xf - s_end;
  assign dist_r   = s_start + s_xf - s_p;
  assign blend_r  = s_end - dist_r;

  // Shared divider.
  logic             div_start;
  logic [DVD_W-1:0] div_dvd, div_q;
  logic [POS_W-1:0] div_dsr, div_r, wrap_res;
  div_stat_t        div_stat;

  always_comb begin
    div_start = 1'b0;
    div_dvd   = DVD_W'(w_mag);
    div_dsr   = len;
    case (state_q)
      S_CHK: begin
        if (!(!playing_q || buf_len_q == '0 || len <= ONE_POS) && !w_in) begin
          div_start = 1'b1;
          div_dvd   = DVD_W'(w_mag);
          div_dsr   = len;
        end
      end
      S_ZONE: begin
        if (zone_fwd || zone_rev) begin
          div_start = 1'b1;
          div_dvd   = zone_fwd ? {DVD_W'(dist_f) << 16} : {DVD_W'(dist_r) << 16};
          div_dsr   = POS_W'(xf_q);
        end
      end
      S_MOVE: begin
        if (!w_in) begin
          div_start = 1'b1;
          div_dvd   = DVD_W'(w_mag);
          div_dsr   = len;
        end
      end
      S_CUTMUL: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'(prod);
        div_dsr   = POS_W'(cnt_q);
      end
      default: ;
    endcase
  end

  lpc_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dvd),
    .divisor_i   (div_dsr),
    .stat_o      (div_stat),
    .quotient_o  (div_q),
    .remainder_o (div_r)
  );

  // Wrapped position from the remainder of the offset by the loop length.
  assign wrap_res = neg_q ? ((div_r == '0) ? start_q : (end_q - div_r))
                          : (start_q + div_r);

  logic [17:0] target;
  assign target = 18'(ls) + 18'(div_q[16:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      playhead_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && m_axis_tready && state_q != S_OUT) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            unique case (op_in)
              OP_TICK: state_q <= S_START;
              OP_SET: begin
                if (buf_len_q == '0) playhead_q <= '0;
                else state_q <= S_SETMUL;
              end
              OP_CUT: begin
                if (buf_len_q != '0 && cnt_in != '0) state_q <= S_CUTMUL;
              end
              default: ;
            endcase
          end
        end
        S_START:  state_q <= S_END;
        S_END:    state_q <= S_STEP;
        S_STEP:   state_q <= S_CHK;
        S_CHK: begin
          if (!playing_q || buf_len_q == '0 || len <= ONE_POS) state_q <= S_OUT;
          else if (w_in) state_q <= S_XF;
          else state_q <= S_WRAP1;
        end
        S_WRAP1:  if (div_stat.done) state_q <= S_XF;
        S_XF:     state_q <= S_ZONE;
        S_ZONE:   state_q <= (zone_fwd || zone_rev) ? S_FADE : S_MOVE;
        S_FADE:   if (div_stat.done) state_q <= S_MOVE;
        S_MOVE:   state_q <= w_in ? S_OUT : S_WRAP2;
        S_WRAP2:  if (div_stat.done) state_q <= S_OUT;
        S_OUT: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            if (!silent_q) playhead_q <= np_q;
            state_q <= S_IDLE;
          end
        end
        S_SETMUL: begin
          playhead_q <= prod[POS_W-1:0];
          state_q    <= S_IDLE;
        end
        S_CUTMUL: state_q <= S_CUTDIV;
        S_CUTDIV: if (div_stat.done) state_q <= S_SETMUL;
        default:  state_q <= S_IDLE;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && s_axis_tvalid) begin
      norm_q <= (pos_in > NORM_ONE) ? NORM_ONE : pos_in;
      idx_q  <= idx_in;
      cnt_q  <= cnt_in;
    end
    if (div_start) neg_q <= w_lt;
    case (state_q)
      S_START: start_q <= prod[POS_W-1:0];
      S_END:   end_q   <= prod[POS_W-1:0];
      S_STEP:  step_q  <= prod[35:13];
      S_CHK: begin
        silent_q <= !playing_q || buf_len_q == '0 || len <= ONE_POS;
        p_q      <= playhead_q;
        active_q <= 1'b0;
        blend_q  <= '0;
        fade_q   <= '0;
      end
      S_WRAP1: if (div_stat.done) p_q <= wrap_res;
      S_XF:    xf_q <= xf_calc;
      S_ZONE: begin
        if (zone_fwd) begin
          active_q <= 1'b1;
          blend_q  <= POS_W'(s_start + dist_f);
        end else if (zone_rev) begin
          active_q <= 1'b1;
          blend_q  <= (blend_r < 0) ? '0 : POS_W'(blend_r);
        end
      end
      S_FADE: begin
        if (div_stat.done)
          fade_q <= (div_q > DVD_W'(NORM_ONE)) ? NORM_ONE : div_q[NORM_W-1:0];
      end
      S_MOVE:  if (w_in) np_q <= POS_W'(s_moved);
      S_WRAP2: if (div_stat.done) np_q <= wrap_res;
      S_CUTDIV: begin
        if (div_stat.done)
          norm_q <= (target > 18'(NORM_ONE)) ? NORM_ONE : target[NORM_W-1:0];
      end
      S_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          if (silent_q) begin
            out_data_q <= '0;
            out_user_q <= 2'b10;
          end else begin
            out_data_q <= {7'd0, fade_q, blend_q, p_q};
            out_user_q <= {1'b0, active_q};
          end
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

`ifndef SYNTH
  a_silent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata[88:0] == '0 && !m_axis_tuser[0]))
    else $error("silent result carries data");
  a_idle_blend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[88:36] == '0))
    else $error("blend data outside the seam zone");
  a_fade_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[88:72] <= NORM_ONE))
    else $error("fade weight above one");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_valid_q && !m_axis_tready) |=> (state_q == S_OUT))
    else $error("result dropped while output full");
`endif

endmodule
